>>> rtl/gaussian_polar_variate_generator_top_defines.svh
// Assertion macros for the polar variate generator.
`ifndef GAUSSIAN_POLAR_VARIATE_GENERATOR_TOP_DEFINES_SVH
`define GAUSSIAN_POLAR_VARIATE_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GPVG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define GPVG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define GPVG_ASSERT_NOW(lbl, ante, cons)
`define GPVG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/gpvg_pkg.sv
// Shared types and constants of the polar variate generator.
package gpvg_pkg;
	localparam int DATA_W = 32;
	localparam int RESULT_FRAC_BITS = 24;
	localparam logic [DATA_W-1:0] SPREAD_RESET = DATA_W'(64'd1 << RESULT_FRAC_BITS);
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_CENTER = 2'd1,
		REG_SPREAD = 2'd2
	} cfg_reg_t;

	localparam int SQ_IN_W = 64;
	localparam int SQ_ROOT_W = 32;
	localparam int SQ_STEPS = 32;

	localparam int DIV_Q_W = 31;
	localparam int DIV_DEN_W = 31;
	localparam int DIV_NUM_W = 62;

	typedef struct packed {
		logic [DATA_W-1:0] first_fraction;
		logic [DATA_W-1:0] second_fraction;
	} pair_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] variate;
		logic                     last_of_pair;
		logic                     clipped;
	} draw_t;
endpackage

>>> rtl/gpvg_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module gpvg_isqrt (
	input  logic                              clk,
	input  logic [gpvg_pkg::SQ_IN_W-1:0]      radicand,
	output logic [gpvg_pkg::SQ_ROOT_W-1:0]    root
);
	import gpvg_pkg::*;

	logic [SQ_IN_W-1:0] rem_q [SQ_STEPS];
	logic [SQ_IN_W-1:0] acc_q [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
		logic [SQ_IN_W-1:0] n_in;
		logic [SQ_IN_W-1:0] r_in;
		logic [SQ_IN_W-1:0] trial;
		if (k == 0) begin : g_first
			assign n_in = radicand;
			assign r_in = '0;
		end else begin : g_next
			assign n_in = rem_q[k-1];
			assign r_in = acc_q[k-1];
		end
		assign trial = r_in + BIT;
		always_ff @(posedge clk) begin
			if (n_in >= trial) begin
				rem_q[k] <= n_in - trial;
				acc_q[k] <= (r_in >> 1) + BIT;
			end else begin
				rem_q[k] <= n_in;
				acc_q[k] <= r_in >> 1;
			end
		end
	end

	assign root = acc_q[SQ_STEPS-1][SQ_ROOT_W-1:0];
endmodule

>>> rtl/gpvg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module gpvg_div (
	input  logic                              clk,
	input  logic [gpvg_pkg::DIV_NUM_W-1:0]    num,
	input  logic [gpvg_pkg::DIV_DEN_W-1:0]    den,
	output logic [gpvg_pkg::DIV_Q_W-1:0]      quot
);
	import gpvg_pkg::*;

	logic [DIV_NUM_W-1:0] rem_q [DIV_Q_W];
	logic [DIV_DEN_W-1:0] den_q [DIV_Q_W];
	logic [DIV_Q_W-1:0]   quo_q [DIV_Q_W];

	for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
		logic [DIV_NUM_W-1:0] n_in;
		logic [DIV_DEN_W-1:0] d_in;
		logic [DIV_Q_W-1:0]   q_in;
		logic [DIV_NUM_W-1:0] trial;
		if (k == 0) begin : g_first
			assign n_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign n_in = rem_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
		end
		assign trial = DIV_NUM_W'(d_in) << (DIV_Q_W - 1 - k);
		always_ff @(posedge clk) begin
			den_q[k] <= d_in;
			if (n_in >= trial) begin
				rem_q[k] <= n_in - trial;
				quo_q[k] <= {q_in[DIV_Q_W-2:0], 1'b1};
			end else begin
				rem_q[k] <= n_in;
				quo_q[k] <= {q_in[DIV_Q_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_q[DIV_Q_W-1];
endmodule

>>> rtl/gaussian_polar_variate_generator_top.sv
// Top level of the polar variate generator: config, pipeline and result port.
// A new pair can be taken while earlier pairs are still in the pipeline; busy
// is high for the cycle after each transfer, as the single result port sends
// the two results of a pair in turn. A rejected pair gives no results.
// The receiver cannot stall; results are strobed for one cycle each.
// Reset: mode normal, center 0, spread 1.0, pipeline empty.
`include "gaussian_polar_variate_generator_top_defines.svh"
module gaussian_polar_variate_generator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  gpvg_pkg::pair_t                    pair,
	input  logic                               cfg_we,
	input  logic [gpvg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [gpvg_pkg::DATA_W-1:0]        cfg_data,
	output logic                               draw_valid,
	output gpvg_pkg::draw_t                    draw
);
	import gpvg_pkg::*;

	typedef struct packed {
		logic              an;
		logic              bn;
		logic [DATA_W-1:0] ua;
		logic [DATA_W-1:0] ub;
	} side_t;

	localparam int LOG_STEPS = 40;
	localparam int ST_NORM = 5;
	localparam int ST_ROOT = ST_NORM + SQ_STEPS;
	localparam int ST_QUOT = ST_ROOT + DIV_Q_W;
	localparam int ST_LOG0 = ST_NORM + 1;
	localparam int ST_LOGN = ST_LOG0 + LOG_STEPS;
	localparam int ST_T = ST_LOGN + 3;
	localparam int ST_G = ST_T + SQ_STEPS;
	localparam int ST_FIN = ST_G + 5;
	localparam logic [32:0] TWO_LN2 = 33'h1_62E4_2FF0;

	function automatic logic [31:0] log_sq(input logic [30:0] m);
		logic [61:0] p;
		logic [31:0] mm;
		p = 62'(m) * 62'(m);
		mm = p[61:30];
		if (mm[31])
			return {1'b1, mm[31:1]};
		else
			return {1'b0, mm[30:0]};
	endfunction

	function automatic logic [32:0] finish(input logic signed [31:0] base,
			input logic [39:0] p, input logic neg);
		logic signed [41:0] pv;
		logic signed [41:0] v;
		pv = $signed({2'b00, p});
		v = 42'(base) + (neg ? -pv : pv);
		if (v > 42'sd2147483647)
			return {1'b1, 32'h7FFF_FFFF};
		else if (v < -42'sd2147483648)
			return {1'b1, 32'h8000_0000};
		else
			return {1'b0, v[31:0]};
	endfunction

	logic                     busy_q;
	logic                     mode_q;
	logic signed [DATA_W-1:0] center_q;
	logic signed [DATA_W-1:0] spread_q;
	logic                     accept;
	logic [ST_FIN:1]          vld_q;

	logic [31:0] am_q [1:4];
	logic [31:0] bm_q [1:4];
	side_t       side_q [1:ST_G+1];
	logic [63:0] sqa_s2, sqb_s2, s_sum;
	logic        keep;
	logic [61:0] s_s3, s_s4;
	logic [4:0]  e_nxt, e_s4;
	logic [61:0] sn_s5;
	logic [4:0]  e_q [ST_NORM:ST_LOGN];
	logic [31:0] amx_q [ST_NORM:ST_ROOT];
	logic [31:0] bmx_q [ST_NORM:ST_ROOT];
	logic [30:0] lm_q [ST_LOG0:ST_LOGN];
	logic [39:0] lf_q [ST_LOG0:ST_LOGN];
	logic        lip_q [ST_LOG0:ST_LOGN];
	logic [45:0] l_s47;
	logic [55:0] tpl_s48, tph_s48;
	logic [79:0] t_sum;
	logic [46:0] t_s49;
	logic [31:0] r_root, g_root;
	logic [30:0] ca_out, cb_out;
	logic [30:0] ca_q [ST_QUOT+1:ST_G];
	logic [30:0] cb_q [ST_QUOT+1:ST_G];
	logic [63:0] pza_s82, pzb_s82, za_sum, zb_sum;
	logic [32:0] smag, dmag, d_diff;
	logic [32:0] x_s83;
	logic [37:0] ya_s83, yb_s83;
	logic        nega_s83, negb_s83, nega_s84, negb_s84, nega_s85, negb_s85;
	logic [51:0] pla_s84, pha_s84, plb_s84, phb_s84;
	logic [71:0] pa_sum, pb_sum;
	logic [39:0] pa_s85, pb_s85;
	logic [32:0] fa_s86, fb_s86, hold_q;
	logic        pend_q;
	logic        draw_valid_q;
	draw_t       draw_q;

	assign accept = start & ~busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= 1'b0;
			center_q <= '0;
			spread_q <= SPREAD_RESET;
			vld_q <= '0;
			pend_q <= 1'b0;
			draw_valid_q <= 1'b0;
		end else begin
			busy_q <= accept;
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:   mode_q <= cfg_data[0];
					REG_CENTER: center_q <= cfg_data;
					REG_SPREAD: spread_q <= cfg_data;
					default:    mode_q <= mode_q;
				endcase
			end
			vld_q <= {vld_q[ST_FIN-1:3], vld_q[2] & keep, vld_q[1], accept};
			pend_q <= vld_q[ST_FIN];
			draw_valid_q <= vld_q[ST_FIN] | pend_q;
		end
	end

	// split each fraction into sign and magnitude of u and v
	always_ff @(posedge clk) begin
		am_q[1] <= pair.first_fraction[31] ? {1'b0, pair.first_fraction[30:0]}
			: 32'h8000_0000 - pair.first_fraction;
		bm_q[1] <= pair.second_fraction[31] ? {1'b0, pair.second_fraction[30:0]}
			: 32'h8000_0000 - pair.second_fraction;
		side_q[1] <= '{an: ~pair.first_fraction[31], bn: ~pair.second_fraction[31],
			ua: pair.first_fraction, ub: pair.second_fraction};
		for (int k = 2; k <= 4; k++) begin
			am_q[k] <= am_q[k-1];
			bm_q[k] <= bm_q[k-1];
		end
		for (int k = 2; k <= ST_G + 1; k++)
			side_q[k] <= side_q[k-1];
	end

	assign s_sum = sqa_s2 + sqb_s2;
	assign keep = mode_q | ((s_sum != '0) && (s_sum[63:62] == 2'b00));

	always_comb begin
		e_nxt = '0;
		for (int j = 30; j >= 0; j--)
			if (|s_s3[61-2*j -: 2])
				e_nxt = 5'(j);
	end

	always_ff @(posedge clk) begin
		sqa_s2 <= 64'(am_q[1]) * 64'(am_q[1]);
		sqb_s2 <= 64'(bm_q[1]) * 64'(bm_q[1]);
		s_s3 <= s_sum[61:0];
		s_s4 <= s_s3;
		e_s4 <= e_nxt;
		sn_s5 <= s_s4 << {e_s4, 1'b0};
		e_q[ST_NORM] <= e_s4;
		amx_q[ST_NORM] <= am_q[4] << e_s4;
		bmx_q[ST_NORM] <= bm_q[4] << e_s4;
		for (int k = ST_NORM + 1; k <= ST_LOGN; k++)
			e_q[k] <= e_q[k-1];
		for (int k = ST_NORM + 1; k <= ST_ROOT; k++) begin
			amx_q[k] <= amx_q[k-1];
			bmx_q[k] <= bmx_q[k-1];
		end
	end

	gpvg_isqrt u_root (
		.clk      (clk),
		.radicand ({2'b00, sn_s5}),
		.root     (r_root)
	);

	gpvg_div u_div_a (
		.clk  (clk),
		.num  ({amx_q[ST_ROOT], 30'b0}),
		.den  (r_root[DIV_DEN_W-1:0]),
		.quot (ca_out)
	);

	gpvg_div u_div_b (
		.clk  (clk),
		.num  ({bmx_q[ST_ROOT], 30'b0}),
		.den  (r_root[DIV_DEN_W-1:0]),
		.quot (cb_out)
	);

	always_ff @(posedge clk) begin
		ca_q[ST_QUOT+1] <= ca_out;
		cb_q[ST_QUOT+1] <= cb_out;
		for (int k = ST_QUOT + 2; k <= ST_G; k++) begin
			ca_q[k] <= ca_q[k-1];
			cb_q[k] <= cb_q[k-1];
		end
	end

	// log2 of the mantissa by repeated squaring
	always_ff @(posedge clk) begin
		lip_q[ST_LOG0] <= sn_s5[61];
		lm_q[ST_LOG0] <= sn_s5[61] ? sn_s5[61:31] : sn_s5[60:30];
		lf_q[ST_LOG0] <= '0;
	end

	for (genvar k = ST_LOG0 + 1; k <= ST_LOGN; k++) begin : g_log
		logic [31:0] sq;
		assign sq = log_sq(lm_q[k-1]);
		always_ff @(posedge clk) begin
			lm_q[k] <= sq[30:0];
			lf_q[k] <= {lf_q[k-1][LOG_STEPS-2:0], sq[31]};
			lip_q[k] <= lip_q[k-1];
		end
	end

	assign t_sum = 80'(tpl_s48) + (80'(tph_s48) << 23) + (80'd1 << 31);

	always_ff @(posedge clk) begin
		l_s47 <= {6'({e_q[ST_LOGN], 1'b0}) + 6'd2, 40'b0}
			- {5'b0, lip_q[ST_LOGN], lf_q[ST_LOGN]};
		tpl_s48 <= 56'(l_s47[22:0]) * 56'(TWO_LN2);
		tph_s48 <= 56'(l_s47[45:23]) * 56'(TWO_LN2);
		t_s49 <= t_sum[78:32];
	end

	gpvg_isqrt u_gain (
		.clk      (clk),
		.radicand ({1'b0, t_s49, 16'b0}),
		.root     (g_root)
	);

	assign za_sum = pza_s82 + (64'd1 << 25);
	assign zb_sum = pzb_s82 + (64'd1 << 25);
	assign smag = spread_q[31] ? 33'(-33'($signed(spread_q))) : 33'(spread_q);
	assign d_diff = 33'($signed(spread_q)) - 33'($signed(center_q));
	assign dmag = d_diff[32] ? -d_diff : d_diff;
	assign pa_sum = 72'(pla_s84) + (72'(pha_s84) << 19) + (72'd1 << 31);
	assign pb_sum = 72'(plb_s84) + (72'(phb_s84) << 19) + (72'd1 << 31);

	always_ff @(posedge clk) begin
		pza_s82 <= 64'(ca_q[ST_G]) * 64'(g_root);
		pzb_s82 <= 64'(cb_q[ST_G]) * 64'(g_root);
		if (mode_q) begin
			x_s83 <= dmag;
			ya_s83 <= 38'(side_q[ST_G+1].ua);
			yb_s83 <= 38'(side_q[ST_G+1].ub);
			nega_s83 <= d_diff[32];
			negb_s83 <= d_diff[32];
		end else begin
			x_s83 <= smag;
			ya_s83 <= za_sum[63:26];
			yb_s83 <= zb_sum[63:26];
			nega_s83 <= side_q[ST_G+1].an ^ spread_q[31];
			negb_s83 <= side_q[ST_G+1].bn ^ spread_q[31];
		end
		pla_s84 <= 52'(x_s83) * 52'(ya_s83[18:0]);
		pha_s84 <= 52'(x_s83) * 52'(ya_s83[37:19]);
		plb_s84 <= 52'(x_s83) * 52'(yb_s83[18:0]);
		phb_s84 <= 52'(x_s83) * 52'(yb_s83[37:19]);
		nega_s84 <= nega_s83;
		negb_s84 <= negb_s83;
		pa_s85 <= pa_sum[71:32];
		pb_s85 <= pb_sum[71:32];
		nega_s85 <= nega_s84;
		negb_s85 <= negb_s84;
		fa_s86 <= finish(center_q, pa_s85, nega_s85);
		fb_s86 <= finish(center_q, pb_s85, negb_s85);
	end

	// first value of a pair goes out at once, hold the second for the next cycle
	always_ff @(posedge clk) begin
		if (vld_q[ST_FIN]) begin
			draw_q.variate <= $signed(fa_s86[31:0]);
			draw_q.last_of_pair <= 1'b0;
			draw_q.clipped <= fa_s86[32];
			hold_q <= fb_s86;
		end else begin
			draw_q.variate <= $signed(hold_q[31:0]);
			draw_q.last_of_pair <= 1'b1;
			draw_q.clipped <= hold_q[32];
		end
	end

	assign draw_valid = draw_valid_q;
	assign draw = draw_q;

	`GPVG_ASSERT_NEXT(a_pair_second, draw_valid && !draw.last_of_pair, draw_valid && draw.last_of_pair)
	`GPVG_ASSERT_NOW(a_pair_first, draw_valid && draw.last_of_pair, $past(draw_valid) && !$past(draw.last_of_pair))
	`GPVG_ASSERT_NOW(a_clip_rail, draw_valid && draw.clipped, draw.variate == 32'sh7FFF_FFFF || draw.variate == $signed(32'h8000_0000))
	`GPVG_ASSERT_NOW(a_spacing, vld_q[1], !vld_q[2])
endmodule
